@@ rtl/smtpclp_pkg.sv @@
package smtpclp_pkg;

    localparam int VERB_BYTES = 16;
    localparam int ARG_BYTES  = 256;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] KW_LEN     = 8'd4;

    localparam logic [7:0] VERB_LAST = 8'(VERB_BYTES - 1);
    localparam logic [7:0] ARG_LAST  = 8'(ARG_BYTES - 1);

    typedef enum logic [2:0] {
        PH_VERB = 3'd0,
        PH_ARG  = 3'd1,
        PH_CR   = 3'd2,
        PH_DONE = 3'd3,
        PH_ERR  = 3'd4
    } phase_t;

    typedef enum logic {
        FIELD_VERB = 1'b0,
        FIELD_ARG  = 1'b1
    } field_t;

    typedef struct packed {
        logic       start_new;
        logic [7:0] byte_in;
    } in_word_t;

    typedef struct packed {
        logic [2:0] parse_phase;
        logic       store_valid;
        logic       store_field;
        logic [7:0] store_index;
        logic       field_closed;
        logic [7:0] closed_length;
        logic       finished;
        logic       errored;
    } out_word_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]})
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    // keyword letters by position
    function automatic logic [7:0] mail_char(input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0: r = 8'h4D;
            2'd1: r = 8'h41;
            2'd2: r = 8'h49;
            default: r = 8'h4C;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcpt_char(input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0: r = 8'h52;
            2'd1: r = 8'h43;
            2'd2: r = 8'h50;
            default: r = 8'h54;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/smtpclp_in_reg.sv @@
module smtpclp_in_reg
    import smtpclp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  in_word_t src_word,
    input  logic     advance,
    output logic     held_valid,
    output in_word_t held_word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     take;

    // hold the word while the stage ahead is blocked
    assign src_stall  = valid_reg && !advance;
    assign take       = src_valid && !src_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= src_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

@@ rtl/smtpclp_parse.sv @@
module smtpclp_parse
    import smtpclp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_word_t  word,
    output out_word_t result
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] fill_reg;
    logic [7:0] fill_next;
    logic       mail_ok_reg;
    logic       mail_ok_next;
    logic       rcpt_ok_reg;
    logic       rcpt_ok_next;

    phase_t     ph;
    logic [7:0] fill;
    logic [7:0] c;
    logic [7:0] cu;
    logic       kw_hit;
    logic       store_ok;

    assign c    = word.byte_in;
    assign cu   = to_upper(c);
    assign ph   = word.start_new ? PH_VERB : phase_reg;
    assign fill = word.start_new ? 8'd0 : fill_reg;
    assign kw_hit = (fill == KW_LEN) && (mail_ok_reg || rcpt_ok_reg);

    // next phase
    always_comb
    begin
        case (ph)
            PH_VERB:
            begin
                if (c == CHAR_CR)
                begin
                    phase_next = PH_CR;
                end
                else if (c == CHAR_COLON)
                begin
                    phase_next = PH_ARG;
                end
                else if (c == CHAR_SPACE)
                begin
                    phase_next = kw_hit ? PH_VERB : PH_ARG;
                end
                else
                begin
                    phase_next = PH_VERB;
                end
            end
            PH_ARG:  phase_next = (c == CHAR_CR) ? PH_CR : PH_ARG;
            PH_CR:   phase_next = (c == CHAR_LF) ? PH_DONE : PH_ERR;
            PH_DONE: phase_next = PH_DONE;
            PH_ERR:  phase_next = PH_ERR;
            default: phase_next = PH_ERR;
        endcase
    end

    // store, close and keyword tracking
    always_comb
    begin
        result               = '0;
        result.parse_phase   = phase_next;
        result.finished      = (phase_next == PH_DONE) || (phase_next == PH_ERR);
        result.errored       = (phase_next == PH_ERR);
        fill_next            = fill;
        mail_ok_next         = mail_ok_reg;
        rcpt_ok_next         = rcpt_ok_reg;
        store_ok             = 1'b0;
        case (ph)
            PH_VERB:
            begin
                result.store_field = FIELD_VERB;
                if (phase_next == PH_VERB)
                begin
                    store_ok = (fill < VERB_LAST);
                end
                else
                begin
                    result.field_closed  = 1'b1;
                    result.closed_length = fill;
                    fill_next            = 8'd0;
                end
            end
            PH_ARG:
            begin
                result.store_field = FIELD_ARG;
                if (phase_next == PH_ARG)
                begin
                    store_ok = (fill < ARG_LAST);
                end
                else
                begin
                    result.field_closed  = 1'b1;
                    result.closed_length = fill;
                    fill_next            = 8'd0;
                end
            end
            default:
            begin
                store_ok = 1'b0;
            end
        endcase
        if (store_ok)
        begin
            result.store_valid = 1'b1;
            result.store_index = fill;
            fill_next          = fill + 8'd1;
        end
        // track the first four verb bytes against both keywords
        if (store_ok && (ph == PH_VERB) && (fill < KW_LEN))
        begin
            mail_ok_next = (cu == mail_char(fill[1:0])) && ((fill == 8'd0) || mail_ok_reg);
            rcpt_ok_next = (cu == rcpt_char(fill[1:0])) && ((fill == 8'd0) || rcpt_ok_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_VERB;
            fill_reg    <= 8'd0;
            mail_ok_reg <= 1'b0;
            rcpt_ok_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            mail_ok_reg <= mail_ok_next;
            rcpt_ok_reg <= rcpt_ok_next;
        end
    end

endmodule

@@ rtl/smtpclp_out_reg.sv @@
module smtpclp_out_reg
    import smtpclp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_valid,
    input  out_word_t load_word,
    output logic      advance,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_word_t dst_word
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;
    logic      load;

    // advance whenever the result slot is empty or being taken
    assign advance    = !valid_reg || !dst_stall;
    assign load       = load_valid && advance;
    assign valid_next = load || (valid_reg && dst_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_word  = word_reg;

endmodule

@@ rtl/smtp_command_line_parser_top.sv @@
// A byte accepted into the input register is parsed into the result register.
// Throughput: one byte per cycle unless dst_stall holds the result register;
// the parse state updates as a byte moves from input to result register.
// Reset (rst_n low, asynchronous): phase returns to verb, fill index to zero,
// both pipeline registers empty.
module smtp_command_line_parser_top
    import smtpclp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_word_t  src_word,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_word_t dst_word
);

    logic      advance;
    logic      held_valid;
    in_word_t  held_word;
    out_word_t parsed;
    logic      fire;

    assign fire = held_valid && advance;

    smtpclp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_word   (src_word),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    smtpclp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (held_word),
        .result (parsed)
    );

    smtpclp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (held_valid),
        .load_word  (parsed),
        .advance    (advance),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_word   (dst_word)
    );

endmodule
